// ----- hdl/gl1n_pkg.sv -----
// ----------------------------------------------------------------------------
// gl1n_pkg: shared types and constants for the grouped L1 command normalizer
// Word layouts of both channels and the fixed Q4.12 format.
// ----------------------------------------------------------------------------
package gl1n_pkg;

    localparam int unsigned WORD_BITS = 16;
    localparam int unsigned Q_FRAC    = 12;
    // |a|+|b|+|c| of three WORD_BITS values fits WORD_BITS+2 bits
    localparam int unsigned SUM_BITS  = WORD_BITS + 2;
    // magnitude shifted up by the fraction bits
    localparam int unsigned NUM_BITS  = WORD_BITS + Q_FRAC;
    // quotient never exceeds 1.0
    localparam int unsigned QUO_BITS  = Q_FRAC + 1;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] yaw_in;
        logic signed [WORD_BITS-1:0] roll_in;
        logic signed [WORD_BITS-1:0] pitch_in;
        logic signed [WORD_BITS-1:0] surge_in;
        logic signed [WORD_BITS-1:0] sway_in;
        logic signed [WORD_BITS-1:0] heave_in;
    } t_cmd_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] yaw_out;
        logic signed [WORD_BITS-1:0] roll_out;
        logic signed [WORD_BITS-1:0] pitch_out;
        logic signed [WORD_BITS-1:0] surge_out;
        logic signed [WORD_BITS-1:0] sway_out;
        logic signed [WORD_BITS-1:0] heave_out;
        logic                        planar_scaled;
        logic                        tilt_scaled;
    } t_cmd_out;

    // one axis travelling down the divider chain
    typedef struct packed {
        logic                  neg;
        logic [NUM_BITS-1:0]   rem;
        logic [QUO_BITS-1:0]   quo;
    } t_lane;

    // one group travelling down the divider chain
    typedef struct packed {
        logic                  scale;
        logic [SUM_BITS-1:0]   sum;
        logic [WORD_BITS-1:0]  raw0;
        logic [WORD_BITS-1:0]  raw1;
        logic [WORD_BITS-1:0]  raw2;
        t_lane                 l0;
        t_lane                 l1;
        t_lane                 l2;
    } t_grp;

    function automatic logic [WORD_BITS:0] mag(input logic signed [WORD_BITS-1:0] v);
        logic [WORD_BITS:0] e;
        e = {v[WORD_BITS-1], v};
        return v[WORD_BITS-1] ? (~e + 1'b1) : e;
    endfunction

endpackage

// ----- hdl/gl1n_cell.sv -----
// ----------------------------------------------------------------------------
// gl1n_cell: one quotient bit of restoring division for both groups
// Holds one item's partial remainders; hands them to the next cell.
// ----------------------------------------------------------------------------
module gl1n_cell
    import gl1n_pkg::*;
#(
    parameter int unsigned BIT_POS = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_grp  i_planar,
    input  t_grp  i_tilt,
    output logic  o_valid,
    output t_grp  o_planar,
    output t_grp  o_tilt
);

    logic r_valid;
    t_grp r_planar, r_tilt, n_planar, n_tilt;

    function automatic t_lane step(input t_lane l, input logic [SUM_BITS-1:0] d);
        t_lane              o;
        logic [NUM_BITS:0]  dsh;
        o   = l;
        dsh = {{(NUM_BITS+1-SUM_BITS){1'b0}}, d} << BIT_POS;
        if ({1'b0, l.rem} >= dsh) begin
            o.rem = NUM_BITS'({1'b0, l.rem} - dsh);
            o.quo[BIT_POS] = 1'b1;
        end
        return o;
    endfunction

    always_comb begin
        n_planar    = i_planar;
        n_tilt      = i_tilt;
        n_planar.l0 = step(i_planar.l0, i_planar.sum);
        n_planar.l1 = step(i_planar.l1, i_planar.sum);
        n_planar.l2 = step(i_planar.l2, i_planar.sum);
        n_tilt.l0   = step(i_tilt.l0, i_tilt.sum);
        n_tilt.l1   = step(i_tilt.l1, i_tilt.sum);
        n_tilt.l2   = step(i_tilt.l2, i_tilt.sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_planar <= n_planar;
            r_tilt   <= n_tilt;
        end
    end

    assign o_valid  = r_valid;
    assign o_planar = r_planar;
    assign o_tilt   = r_tilt;

endmodule

// ----- hdl/grouped_l1_command_normalizer.sv -----
// ----------------------------------------------------------------------------
// grouped_l1_command_normalizer: L1 normalization of two three-axis groups
// Divides each group by its sum of magnitudes when that sum exceeds 1.0.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one six-axis command word; output
// channel o_valid/i_stall returns the normalized word with two scale flags.
// A word is taken when valid is high and stall is low.
// Pipeline: one entry register that forms the sums, then a chain of 13
// divider cells, one quotient bit each, then the output register.
// Throughput: one word per cycle while not stalled. The chain advances as a
// whole whenever the output register is empty or being read, so o_stall
// follows i_stall only while the output word is held.
// On stall the whole chain holds and the output word stays stable.
// Reset (synchronous, active low) drops all words in flight.
// ----------------------------------------------------------------------------
module grouped_l1_command_normalizer
    import gl1n_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_cmd_in  i_cmd,
    output logic     o_valid,
    input  logic     i_stall,
    output t_cmd_out o_cmd
);

    localparam int unsigned N_CELLS = QUO_BITS;
    localparam logic [SUM_BITS-1:0] ONE_Q = SUM_BITS'(1) << Q_FRAC;

    logic  adv;
    logic  r_out_valid;
    t_cmd_out r_out, n_out;
    logic  r_in_valid;
    t_grp  r_in_p, r_in_t, n_in_p, n_in_t;

    logic           v_chain [N_CELLS+1];
    t_grp           p_chain [N_CELLS+1];
    t_grp           t_chain [N_CELLS+1];

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    function automatic t_lane load(input logic signed [WORD_BITS-1:0] v);
        t_lane l;
        l.neg = v[WORD_BITS-1];
        l.rem = NUM_BITS'(mag(v)) << Q_FRAC;
        l.quo = '0;
        return l;
    endfunction

    function automatic t_grp form(input logic signed [WORD_BITS-1:0] a,
                                  input logic signed [WORD_BITS-1:0] b,
                                  input logic signed [WORD_BITS-1:0] c);
        t_grp g;
        g.sum   = SUM_BITS'(mag(a)) + SUM_BITS'(mag(b)) + SUM_BITS'(mag(c));
        g.scale = g.sum > ONE_Q;
        g.raw0  = a;
        g.raw1  = b;
        g.raw2  = c;
        g.l0    = load(a);
        g.l1    = load(b);
        g.l2    = load(c);
        return g;
    endfunction

    // zero sum means all raw members are zero, so passing them is correct
    function automatic logic [WORD_BITS-1:0] pick(input t_grp g, input t_lane l,
                                                  input logic [WORD_BITS-1:0] raw);
        logic [WORD_BITS-1:0] q;
        q = WORD_BITS'(l.quo);
        if (!g.scale) return raw;
        return l.neg ? (~q + 1'b1) : q;
    endfunction

    assign n_in_p = form(i_cmd.yaw_in, i_cmd.surge_in, i_cmd.sway_in);
    assign n_in_t = form(i_cmd.roll_in, i_cmd.pitch_in, i_cmd.heave_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_valid;
        end
        if (adv) begin
            r_in_p <= n_in_p;
            r_in_t <= n_in_t;
        end
    end

    assign v_chain[0] = r_in_valid;
    assign p_chain[0] = r_in_p;
    assign t_chain[0] = r_in_t;

    // cell k resolves quotient bit N_CELLS-1-k, most significant first
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        gl1n_cell #(
            .BIT_POS(N_CELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_chain[k]),
            .i_planar(p_chain[k]),
            .i_tilt  (t_chain[k]),
            .o_valid (v_chain[k+1]),
            .o_planar(p_chain[k+1]),
            .o_tilt  (t_chain[k+1])
        );
    end

    always_comb begin
        t_grp p, t;
        p = p_chain[N_CELLS];
        t = t_chain[N_CELLS];
        n_out.yaw_out       = pick(p, p.l0, p.raw0);
        n_out.surge_out     = pick(p, p.l1, p.raw1);
        n_out.sway_out      = pick(p, p.l2, p.raw2);
        n_out.roll_out      = pick(t, t.l0, t.raw0);
        n_out.pitch_out     = pick(t, t.l1, t.raw1);
        n_out.heave_out     = pick(t, t.l2, t.raw2);
        n_out.planar_scaled = p.scale;
        n_out.tilt_scaled   = t.scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= v_chain[N_CELLS];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = r_out;

endmodule
